### hw/rtl/gpmj_pkg.sv
// Package for the game-port mouse and joystick register block.
// Holds the action codes, register selector and configuration indexes, and the stage item type.
// Depends on nothing.
`default_nettype none

package gpmj_pkg;

	typedef enum logic [1:0] {
		ACT_MOUSE = 2'd0,
		ACT_JOY   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_TEST  = 2'd3
	} action_t;

	localparam logic [2:0] SEL_JOY0DAT = 3'd0;
	localparam logic [2:0] SEL_JOY1DAT = 3'd1;
	localparam logic [2:0] SEL_POT0DAT = 3'd2;
	localparam logic [2:0] SEL_POT1DAT = 3'd3;
	localparam logic [2:0] SEL_POTGOR  = 3'd4;

	localparam logic [1:0] CFG_PORT0_SOURCE = 2'd0;
	localparam logic [1:0] CFG_PORT1_SOURCE = 2'd1;
	localparam logic [1:0] CFG_POTGOR_BASE  = 2'd2;

	localparam logic [3:0]  MOUSE_CODE       = 4'd1;
	localparam logic [3:0]  PORT0_SRC_RESET  = 4'd1;
	localparam logic [3:0]  PORT1_SRC_RESET  = 4'd0;
	localparam logic [15:0] POTGOR_RESET     = 16'hffff;
	localparam logic [15:0] POTGOR_KEEP_MASK = 16'hbbff;
	localparam logic [15:0] POTGOR_P0_BIT    = 16'h0400;
	localparam logic [15:0] POTGOR_P1_BIT    = 16'h4000;
	localparam logic [15:0] POT_STEP         = 16'h0100;
	localparam logic [15:0] JOY_RIGHT_BITS   = 16'h0003;
	localparam logic [15:0] JOY_LEFT_BITS    = 16'h0300;
	localparam logic [15:0] JOY_UP_BIT       = 16'h0100;
	localparam logic [15:0] JOY_DOWN_BIT     = 16'h0001;
	localparam logic signed [31:0] STEP_MAX  = 32'sd127;
	localparam logic signed [31:0] STEP_MIN  = -32'sd127;

	typedef struct packed {
		action_t            action;
		logic [3:0]         device;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [3:0]         dirs;
		logic               button_primary;
		logic               button_secondary;
		logic [2:0]         register_select;
		logic [15:0]        write_data;
	} item_t;

endpackage

`default_nettype wire

### hw/rtl/gameport_mouse_joystick_registers.sv
// Top level of the two-port mouse and joystick register block.
// Uses gpmj_pkg for codes, constants and the stage item type.
//
// Channel   Signals                                   Direction
// input     in_valid, in_ready, action .. write_data   into block
// output    out_valid, out_ready, read_data            out of block
// config    cfg_we, cfg_index, cfg_wdata               into block
//
// An item is taken into the stage register, and from there it updates the port
// state and, for a read, loads the output register: one item per cycle sustained.
// Only a read waiting on a full, stalled output register holds the stage back.
// Reset clears all port state and the valid flags, and loads the configuration
// registers with their reset values.
`default_nettype none

module gameport_mouse_joystick_registers (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic [3:0]         device,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic               move_left,
	input  wire logic               move_up,
	input  wire logic               move_right,
	input  wire logic               move_down,
	input  wire logic               button_primary,
	input  wire logic               button_secondary,
	input  wire logic [2:0]         register_select,
	input  wire logic [15:0]        write_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             read_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_wdata
);

	logic [3:0]  port0_source_q;
	logic [3:0]  port1_source_q;
	logic [15:0] potgor_base_q;

	gpmj_pkg::item_t item_s1;
	logic            valid_s1;

	logic [31:0] pos_x_q      [2];
	logic [31:0] pos_y_q      [2];
	logic [31:0] reported_x_q [2];
	logic [31:0] reported_y_q [2];
	logic [3:0]  dir_bits_q   [2];
	logic        fire_pri_q   [2];
	logic        fire_sec_q   [2];
	logic [15:0] pot_count_q  [2];

	logic        out_valid_q;
	logic [15:0] read_data_q;

	logic        in_xfer;
	logic        out_free;
	logic        is_read_s1;
	logic        adv_s1;
	logic [1:0]  port_hit;
	logic        rport;
	logic        rd_mouse;
	logic        rd_joy;
	logic signed [31:0] diff_x;
	logic signed [31:0] diff_y;
	logic signed [31:0] step_x;
	logic signed [31:0] step_y;
	logic [31:0] new_rep_x;
	logic [31:0] new_rep_y;
	logic [3:0]  rdir;
	logic [15:0] joy_val;
	logic [15:0] rd_val;
	logic [31:0] test_x;
	logic [31:0] test_y;

	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign is_read_s1 = item_s1.action == gpmj_pkg::ACT_READ;
	assign adv_s1     = valid_s1 && (!is_read_s1 || out_free);
	assign in_ready   = !valid_s1 || adv_s1;
	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port0_source_q <= gpmj_pkg::PORT0_SRC_RESET;
			port1_source_q <= gpmj_pkg::PORT1_SRC_RESET;
			potgor_base_q  <= gpmj_pkg::POTGOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpmj_pkg::CFG_PORT0_SOURCE: port0_source_q <= cfg_wdata[3:0];
				gpmj_pkg::CFG_PORT1_SOURCE: port1_source_q <= cfg_wdata[3:0];
				gpmj_pkg::CFG_POTGOR_BASE:  potgor_base_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.action           <= gpmj_pkg::action_t'(action);
			item_s1.device           <= device;
			item_s1.delta_x          <= delta_x;
			item_s1.delta_y          <= delta_y;
			item_s1.dirs             <= {move_down, move_right, move_up, move_left};
			item_s1.button_primary   <= button_primary;
			item_s1.button_secondary <= button_secondary;
			item_s1.register_select  <= register_select;
			item_s1.write_data       <= write_data;
		end
	end

	always_comb begin
		port_hit[0] = port0_source_q == item_s1.device;
		port_hit[1] = port1_source_q == item_s1.device;
		rport       = item_s1.register_select[0];
		rd_mouse    = (rport ? port1_source_q : port0_source_q) == gpmj_pkg::MOUSE_CODE;
		rd_joy      = item_s1.register_select == gpmj_pkg::SEL_JOY0DAT
			|| item_s1.register_select == gpmj_pkg::SEL_JOY1DAT;

		diff_x = signed'(pos_x_q[rport] - reported_x_q[rport]);
		diff_y = signed'(pos_y_q[rport] - reported_y_q[rport]);
		if (diff_x > gpmj_pkg::STEP_MAX) begin
			step_x = gpmj_pkg::STEP_MAX;
		end else if (diff_x < gpmj_pkg::STEP_MIN) begin
			step_x = gpmj_pkg::STEP_MIN;
		end else begin
			step_x = diff_x;
		end
		if (diff_y > gpmj_pkg::STEP_MAX) begin
			step_y = gpmj_pkg::STEP_MAX;
		end else if (diff_y < gpmj_pkg::STEP_MIN) begin
			step_y = gpmj_pkg::STEP_MIN;
		end else begin
			step_y = diff_y;
		end
		new_rep_x = reported_x_q[rport] + unsigned'(step_x);
		new_rep_y = reported_y_q[rport] + unsigned'(step_y);

		rdir    = dir_bits_q[rport];
		joy_val = '0;
		if (rdir[2]) joy_val = joy_val | gpmj_pkg::JOY_RIGHT_BITS;
		if (rdir[0]) joy_val = joy_val | gpmj_pkg::JOY_LEFT_BITS;
		if (rdir[1]) joy_val = joy_val ^ gpmj_pkg::JOY_UP_BIT;
		if (rdir[3]) joy_val = joy_val ^ gpmj_pkg::JOY_DOWN_BIT;

		unique case (item_s1.register_select)
			gpmj_pkg::SEL_JOY0DAT,
			gpmj_pkg::SEL_JOY1DAT:
				rd_val = rd_mouse ? {new_rep_y[7:0], new_rep_x[7:0]} : joy_val;
			gpmj_pkg::SEL_POT0DAT: rd_val = pot_count_q[0];
			gpmj_pkg::SEL_POT1DAT: rd_val = pot_count_q[1];
			gpmj_pkg::SEL_POTGOR: begin
				rd_val = potgor_base_q & gpmj_pkg::POTGOR_KEEP_MASK;
				if (!fire_sec_q[0]) rd_val = rd_val | gpmj_pkg::POTGOR_P0_BIT;
				if (!fire_sec_q[1]) rd_val = rd_val | gpmj_pkg::POTGOR_P1_BIT;
			end
			default: rd_val = '0;
		endcase

		test_x = {{24{item_s1.write_data[7]}}, item_s1.write_data[7:0]};
		test_y = {{24{item_s1.write_data[15]}}, item_s1.write_data[15:8]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 2; p++) begin
				pos_x_q[p]      <= '0;
				pos_y_q[p]      <= '0;
				reported_x_q[p] <= '0;
				reported_y_q[p] <= '0;
				dir_bits_q[p]   <= '0;
				fire_pri_q[p]   <= 1'b0;
				fire_sec_q[p]   <= 1'b0;
				pot_count_q[p]  <= '0;
			end
		end else if (adv_s1) begin
			unique case (item_s1.action)
				gpmj_pkg::ACT_MOUSE,
				gpmj_pkg::ACT_JOY: begin
					for (int p = 0; p < 2; p++) begin
						if (port_hit[p]) begin
							if (!fire_sec_q[p] && item_s1.button_secondary) begin
								pot_count_q[p] <= pot_count_q[p] + gpmj_pkg::POT_STEP;
							end
							fire_pri_q[p] <= item_s1.button_primary;
							fire_sec_q[p] <= item_s1.button_secondary;
							if (item_s1.action == gpmj_pkg::ACT_MOUSE) begin
								pos_x_q[p] <= pos_x_q[p]
									+ {{16{item_s1.delta_x[15]}}, item_s1.delta_x};
								pos_y_q[p] <= pos_y_q[p]
									+ {{16{item_s1.delta_y[15]}}, item_s1.delta_y};
							end else begin
								dir_bits_q[p] <= item_s1.dirs;
							end
						end
					end
				end
				gpmj_pkg::ACT_TEST: begin
					for (int p = 0; p < 2; p++) begin
						pos_x_q[p]      <= test_x;
						pos_y_q[p]      <= test_y;
						reported_x_q[p] <= test_x;
						reported_y_q[p] <= test_y;
					end
				end
				gpmj_pkg::ACT_READ: begin
					if (rd_joy && rd_mouse) begin
						reported_x_q[rport] <= new_rep_x;
						reported_y_q[rport] <= new_rep_y;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_read_s1) begin
			read_data_q <= rd_val;
		end
	end

`ifndef SYNTHESIS
	// Events and test writes never wait on the output register.
	a_nonread_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_read_s1 |-> adv_s1)
		else $error("non-read item held in stage");

	// A new transfer never overwrites an item that has not moved on.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> (!valid_s1 || adv_s1))
		else $error("stage overrun");

	// Every read that leaves the stage presents a result next cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && is_read_s1 |=> out_valid_q)
		else $error("read produced no result");

	// A test write leaves position and reported value equal; checked for x on port 0 and y on port 1.
	a_test_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.action == gpmj_pkg::ACT_TEST |=>
		pos_x_q[0] == reported_x_q[0] && pos_y_q[1] == reported_y_q[1])
		else $error("test write load mismatch");
`endif

endmodule

`default_nettype wire
